// ===== rtl/core/sva_pkg.sv =====
// ----------------------------------------------------------------------------
// sva_pkg
// Shared types and fixed widths for the sample variance accumulator.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned VarW    = 39;
  localparam int unsigned MeanW   = 16;
  localparam int unsigned FracW   = 8;

  localparam logic [VarW-1:0] VarMax = {VarW{1'b1}};

  // Group finish sequencer
  typedef enum logic [2:0] {
    FIN_IDLE,
    FIN_MUL,
    FIN_SUB,
    FIN_DIV,
    FIN_DONE
  } fin_state_e;

endpackage

// ===== rtl/core/sample_variance_accumulator.sv =====
// ----------------------------------------------------------------------------
// sample_variance_accumulator
// Running sum / sum of squares over groups of SAMPLES signed samples; emits
// the unbiased variance (8 fraction bits, saturating) and the truncated mean.
// ----------------------------------------------------------------------------
//  channel | direction | signals                          | moves
//  --------+-----------+----------------------------------+--------------------
//  in      | input     | in_valid_i, in_ready_o, sample_i | one sample
//  out     | output    | out_valid_o, out_ready_i,        | one result per group
//          |           | variance_o, group_mean_o         |
//
//  A sample is accepted every cycle except in the stall described below; its
//  square and both sums update at the accepting edge. The last sample of a
//  group starts the finish path: a multiply state (|S1|^2, N*S2, mean by
//  reciprocal), a subtract state, 32x32 partial products for the division by
//  N*(N-1), then the result register loads once the output is free. Only the
//  next group's last sample stalls, while that path or a waiting result is
//  busy. Reset clears the sums and control state.
module sample_variance_accumulator #(
  parameter int unsigned SAMPLES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [sva_pkg::SampleW-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sva_pkg::VarW-1:0]     variance_o,
  output logic signed [sva_pkg::MeanW-1:0]   group_mean_o
);
  import sva_pkg::*;

  localparam int unsigned ClogW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned CntW   = ClogW;
  localparam int unsigned SumW   = SampleW + ClogW;
  localparam int unsigned SqsW   = 2 * SampleW + ClogW;
  localparam int unsigned NumW   = 2 * SumW;
  localparam int unsigned DvdW   = NumW + FracW;

  // floor(x / D) == (x * VarRecip) >> VarSh for every x below 2**DvdW
  localparam int unsigned VarDenV = SAMPLES * (SAMPLES - 1);
  localparam int unsigned VarLog  = $clog2(VarDenV);
  localparam int unsigned VarSh   = DvdW + VarLog;
  localparam int unsigned RecW    = DvdW + 2;
  localparam int unsigned QuoW    = DvdW + 2 - VarLog;
  localparam int unsigned PW      = 32;
  localparam int unsigned XP      = (DvdW + PW - 1) / PW;
  localparam int unsigned MP      = (RecW + PW - 1) / PW;
  localparam int unsigned XPadW   = XP * PW;
  localparam int unsigned MPadW   = MP * PW;
  localparam int unsigned AccW    = XPadW + MPadW;
  localparam int unsigned XiW     = (XP > 1) ? $clog2(XP) : 1;
  localparam int unsigned MjW     = (MP > 1) ? $clog2(MP) : 1;
  localparam int unsigned PosW    = $clog2(XP + MP);

  // same scheme for the mean magnitude, |S1| below 2**SumW
  localparam int unsigned MeanSh   = SumW + ClogW;
  localparam int unsigned MeanRecW = SumW + 2;
  localparam int unsigned MProdW   = SumW + MeanRecW;

  localparam logic [CntW-1:0]  LastCnt  = CntW'(SAMPLES - 1);
  localparam logic [NumW-1:0]  NumScale = NumW'(SAMPLES);
  localparam logic [XiW-1:0]   LastXi   = XiW'(XP - 1);
  localparam logic [MjW-1:0]   LastMj   = MjW'(MP - 1);

  localparam logic [VarSh:0]   VarPow   = {1'b1, {VarSh{1'b0}}};
  localparam logic [VarSh:0]   VarCeil  = (VarPow + (VarSh+1)'(VarDenV - 1)) /
                                          (VarSh+1)'(VarDenV);
  localparam logic [MPadW-1:0] VarRecip = MPadW'(VarCeil);

  localparam logic [MeanSh:0]     MeanPow   = {1'b1, {MeanSh{1'b0}}};
  localparam logic [MeanSh:0]     MeanCeil  = (MeanPow + (MeanSh+1)'(SAMPLES - 1)) /
                                              (MeanSh+1)'(SAMPLES);
  localparam logic [MeanRecW-1:0] MeanRecip = MeanRecW'(MeanCeil);

  // ---------------- accumulation ----------------
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SqsW-1:0]        sqs_q, sqs_d;
  logic signed [2*SampleW-1:0] sample_sq;
  logic in_fire, last_fire;

  fin_state_e fin_q, fin_d;

  assign in_ready_o = !((cnt_q == LastCnt) && (fin_q != FIN_IDLE));
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_fire  = in_fire && (cnt_q == LastCnt);

  assign sample_sq = sample_i * sample_i;

  always_comb begin
    sum_d = sum_q + SumW'(sample_i);
    sqs_d = sqs_q + SqsW'($unsigned(sample_sq));
    cnt_d = cnt_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sqs_q <= '0;
    end else if (in_fire) begin
      if (last_fire) begin
        cnt_q <= '0;
        sum_q <= '0;
        sqs_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        sum_q <= sum_d;
        sqs_q <= sqs_d;
      end
    end
  end

  // ---------------- finish sequencer ----------------
  logic signed [SumW-1:0] fs1_q;
  logic [SqsW-1:0]        fs2_q;
  logic [SumW-1:0]        fabs;
  logic [NumW-1:0]        abs_sq_q, nsq_q, num;
  logic [MProdW-1:0]      mean_prod;
  logic [MeanW-1:0]       mean_mag_q;
  logic [XPadW-1:0]       dvd_q;
  logic [AccW-1:0]        acc_q;
  logic [XiW-1:0]         xi_q;
  logic [MjW-1:0]         mj_q;
  logic [PosW-1:0]        pp_pos;
  logic [PW-1:0]          x_piece, m_piece;
  logic [2*PW-1:0]        pp;
  logic [QuoW-1:0]        var_quo;
  logic                   out_valid_q;
  logic                   out_free, div_last;
  logic                   ld_mul, ld_sub, do_div, ld_out;

  assign fabs      = fs1_q[SumW-1] ? SumW'(-fs1_q) : SumW'(fs1_q);
  assign num       = (nsq_q > abs_sq_q) ? (nsq_q - abs_sq_q) : '0;
  assign mean_prod = MProdW'(fabs) * MProdW'(MeanRecip);
  assign out_free  = !out_valid_q || out_ready_i;
  assign div_last  = (xi_q == LastXi) && (mj_q == LastMj);

  // one 32x32 partial product of dividend times reciprocal per cycle
  assign x_piece = dvd_q[PW*xi_q +: PW];
  assign m_piece = VarRecip[PW*mj_q +: PW];
  assign pp      = (2*PW)'(x_piece) * (2*PW)'(m_piece);
  assign pp_pos  = PosW'(xi_q) + PosW'(mj_q);
  assign var_quo = acc_q[VarSh +: QuoW];

  always_comb begin
    fin_d = fin_q;
    unique case (fin_q)
      FIN_IDLE: if (last_fire) fin_d = FIN_MUL;
      FIN_MUL:  fin_d = FIN_SUB;
      FIN_SUB:  fin_d = FIN_DIV;
      FIN_DIV:  if (div_last) fin_d = FIN_DONE;
      FIN_DONE: if (out_free) fin_d = FIN_IDLE;
      default:  fin_d = FIN_IDLE;
    endcase
  end

  always_comb begin
    ld_mul = 1'b0;
    ld_sub = 1'b0;
    do_div = 1'b0;
    ld_out = 1'b0;
    unique case (fin_q)
      FIN_MUL:  ld_mul = 1'b1;
      FIN_SUB:  ld_sub = 1'b1;
      FIN_DIV:  do_div = 1'b1;
      FIN_DONE: ld_out = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= FIN_IDLE;
    end else begin
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_fire) begin
      fs1_q <= sum_d;
      fs2_q <= sqs_d;
    end
    if (ld_mul) begin
      abs_sq_q   <= NumW'(fabs) * NumW'(fabs);
      nsq_q      <= NumW'(fs2_q) * NumScale;
      mean_mag_q <= mean_prod[MeanSh +: MeanW];
    end
    if (ld_sub) begin
      dvd_q <= XPadW'({num, {FracW{1'b0}}});
      acc_q <= '0;
      xi_q  <= '0;
      mj_q  <= '0;
    end else if (do_div) begin
      acc_q <= acc_q + (AccW'(pp) << (PW * pp_pos));
      if (mj_q == LastMj) begin
        mj_q <= '0;
        xi_q <= xi_q + XiW'(1);
      end else begin
        mj_q <= mj_q + MjW'(1);
      end
    end
  end

  // ---------------- result register ----------------
  logic [MeanW-1:0] mean_full;

  assign mean_full = fs1_q[SumW-1] ? (MeanW'(0) - mean_mag_q) : mean_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      variance_o   <= (|var_quo[QuoW-1:VarW]) ? VarMax : var_quo[VarW-1:0];
      group_mean_o <= $signed(mean_full);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/variance_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variance_checker
// Watches both channels of the sample variance accumulator. It keeps its own
// running sums and predicts the variance and mean of every completed group,
// then compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module variance_checker #(
  parameter int unsigned SAMPLES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic signed [sva_pkg::SampleW-1:0] sample_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [sva_pkg::VarW-1:0]           variance_i,
  input  logic signed [sva_pkg::MeanW-1:0]   group_mean_i,
  output int unsigned                        mismatches_o,
  output int unsigned                        pending_o,
  output int unsigned                        groups_checked_o
);
  import sva_pkg::*;

  localparam int unsigned SumW   = SampleW + $clog2(SAMPLES);
  localparam int unsigned SqW    = 2 * SampleW + $clog2(SAMPLES);
  localparam int unsigned CountW = (SAMPLES > 2) ? $clog2(SAMPLES) : 1;

  typedef struct packed {
    logic [VarW-1:0]         variance;
    logic signed [MeanW-1:0] mean;
  } group_stats_t;

  logic signed [SumW-1:0] group_sum    = '0;
  logic [SqW-1:0]         group_sq_sum = '0;
  logic [CountW-1:0]      group_count  = '0;
  group_stats_t           group_stats_q[$];
  group_stats_t           oldest;
  int unsigned            fails   = 0;
  int unsigned            matched = 0;

  // Unbiased variance (N*S2 - S1^2) / (N*(N-1)) with 8 fraction bits, floored
  function automatic group_stats_t finish_group(input logic signed [SumW-1:0] total,
                                                input logic [SqW-1:0] sq_total);
    longint       wide_sum;
    logic [63:0]  magnitude;
    logic [63:0]  sum_squared;
    logic [63:0]  numer;
    logic [63:0]  quotient;
    group_stats_t stats;
    wide_sum    = total;
    magnitude   = (wide_sum < 0) ? -wide_sum : wide_sum;
    sum_squared = magnitude * magnitude;
    numer       = 64'(SAMPLES) * 64'(sq_total);
    numer       = (numer > sum_squared) ? numer - sum_squared : 64'd0;
    quotient    = (numer << FracW) / (64'(SAMPLES) * 64'(SAMPLES - 1));
    stats.variance = (quotient > 64'(VarMax)) ? VarMax : quotient[VarW-1:0];
    // signed division truncates toward zero
    stats.mean     = MeanW'(wide_sum / longint'(SAMPLES));
    return stats;
  endfunction

  task automatic take_sample(input logic signed [SampleW-1:0] value);
    logic signed [2*SampleW-1:0] square;
    logic signed [SumW-1:0]      next_sum;
    logic [SqW-1:0]              next_sq;
    square   = value * value;
    next_sum = group_sum + SumW'(value);
    next_sq  = group_sq_sum + SqW'($unsigned(square));
    if (group_count == CountW'(SAMPLES - 1)) begin
      group_stats_q.push_back(finish_group(next_sum, next_sq));
      group_sum    = '0;
      group_sq_sum = '0;
      group_count  = '0;
    end else begin
      group_sum    = next_sum;
      group_sq_sum = next_sq;
      group_count  = group_count + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_sum    = '0;
      group_sq_sum = '0;
      group_count  = '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        take_sample(sample_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (group_stats_q.size() == 0) begin
          $error("result transaction with no group pending: variance %0d mean %0d",
                 variance_i, group_mean_i);
          fails++;
        end else begin
          oldest = group_stats_q.pop_front();
          matched++;
          if (variance_i !== oldest.variance) begin
            $error("variance mismatch: expected %0d, got %0d", oldest.variance, variance_i);
            fails++;
          end
          if (group_mean_i !== oldest.mean) begin
            $error("group_mean mismatch: expected %0d, got %0d", oldest.mean, group_mean_i);
            fails++;
          end
        end
      end
    end
    mismatches_o     <= fails;
    pending_o        <= group_stats_q.size();
    groups_checked_o <= matched;
  end

endmodule

// ===== tb/sample_variance_accumulator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_variance_accumulator_test
// Streams groups of signed samples into the accumulator with random gaps and
// output back-pressure, including one long output hold-off; the checker
// predicts and compares every group result.
// ----------------------------------------------------------------------------
module sample_variance_accumulator_test;
  import sva_pkg::*;

  localparam int unsigned Samples     = 16;
  localparam int unsigned TargetItems = 1650;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned CycleLimit  = 200000;

  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic signed [SampleW-1:0] SampleMax = ~SampleMin;

  // Content of one group of samples
  typedef enum int unsigned {
    MIX_ALTERNATE,
    MIX_FLOOR,
    MIX_FULL,
    MIX_NEAR_ZERO,
    MIX_FLAT,
    MIX_EXTREMES,
    MIX_SPIKE
  } group_mix_e;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic signed [SampleW-1:0] sample_i    = '0;
  logic                      out_ready_i = 1'b0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic [VarW-1:0]           variance_o;
  logic signed [MeanW-1:0]   group_mean_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned groups_checked;
  int unsigned samples_sent = 0;
  int unsigned groups_sent  = 0;
  int unsigned cycles       = 0;
  bit          quiet_phase  = 1'b0;
  bit          squeeze_go   = 1'b0;
  bit          squeezed     = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sample_variance_accumulator #(
    .SAMPLES (Samples)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .variance_o   (variance_o),
    .group_mean_o (group_mean_o)
  );

  variance_checker #(
    .SAMPLES (Samples)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .sample_i         (sample_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .variance_i       (variance_o),
    .group_mean_i     (group_mean_o),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .groups_checked_o (groups_checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $error("timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SampleW-1:0] value);
    while (!quiet_phase && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    samples_sent++;
  endtask

  task automatic send_group(input group_mix_e mix);
    logic signed [SampleW-1:0] level;
    logic signed [SampleW-1:0] value;
    int unsigned               spike_at;
    level    = SampleW'($urandom());
    spike_at = $urandom_range(Samples - 1);
    for (int unsigned k = 0; k < Samples; k++) begin
      case (mix)
        MIX_ALTERNATE: value = k[0] ? SampleMax : SampleMin;
        MIX_FLOOR:     value = SampleMin;
        MIX_NEAR_ZERO: value = SampleW'($signed($urandom_range(8)) - 4);
        MIX_FLAT:      value = level;
        MIX_EXTREMES:  value = $urandom_range(1) ? SampleMax : SampleMin;
        MIX_SPIKE:     value = (k == spike_at) ? SampleW'($urandom()) : level;
        default:       value = SampleW'($urandom());
      endcase
      send_sample(value);
    end
    groups_sent++;
  endtask

  function automatic group_mix_e pick_mix();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return MIX_FULL;
    if (roll < 70) return MIX_NEAR_ZERO;
    if (roll < 80) return MIX_FLAT;
    if (roll < 90) return MIX_EXTREMES;
    return MIX_SPIKE;
  endfunction

  // Result side: random stalls, plus one long hold-off that backs up the block
  initial begin
    forever begin
      if (squeeze_go && !squeezed) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        squeezed = 1'b1;
      end else begin
        out_ready_i <= quiet_phase || ($urandom_range(99) >= 16);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes: widest spread, then a flat group at the most negative value
    send_group(MIX_ALTERNATE);
    send_group(MIX_FLOOR);

    while (samples_sent < TargetItems) begin
      if (groups_sent == 8) squeeze_go = 1'b1;
      quiet_phase = (groups_sent >= 40) && (groups_sent < 58);
      send_group(pick_mix());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d samples in %0d groups; %0d group results compared.",
             samples_sent, groups_sent, groups_checked);
    $display("Random gaps on both sides, one gap-free stretch, one %0d-cycle output hold-off.",
             HoldCycles);
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
